### rtl/mdsc_pkg.sv
package mdsc_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned KindWidth  = 4;

    localparam logic [CharWidth-1:0] ChTerm  = 8'h00;
    localparam logic [CharWidth-1:0] ChOpen  = 8'h28;
    localparam logic [CharWidth-1:0] ChClose = 8'h29;
    localparam logic [CharWidth-1:0] ChLong  = 8'h4A;
    localparam logic [CharWidth-1:0] ChDbl   = 8'h44;
    localparam logic [CharWidth-1:0] ChRef   = 8'h4C;
    localparam logic [CharWidth-1:0] ChArray = 8'h5B;
    localparam logic [CharWidth-1:0] ChSemi  = 8'h3B;
    localparam logic [CharWidth-1:0] ChVoid  = 8'h56;
    localparam logic [CharWidth-1:0] ChFloat = 8'h46;
    localparam logic [CharWidth-1:0] ChByte  = 8'h42;
    localparam logic [CharWidth-1:0] ChChar  = 8'h43;
    localparam logic [CharWidth-1:0] ChShort = 8'h53;
    localparam logic [CharWidth-1:0] ChBool  = 8'h5A;
    localparam logic [CharWidth-1:0] ChInt   = 8'h49;

    typedef enum logic [2:0] {
        MODE_OPEN  = 3'd0,
        MODE_ARGS  = 3'd1,
        MODE_CLASS = 3'd2,
        MODE_ARRAY = 3'd3,
        MODE_RET   = 3'd4,
        MODE_DRAIN = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_BAD      = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [KindWidth-1:0] {
        KIND_VOID   = 4'd0,
        KIND_LONG   = 4'd1,
        KIND_FLOAT  = 4'd2,
        KIND_DOUBLE = 4'd3,
        KIND_BYTE   = 4'd4,
        KIND_CHAR   = 4'd5,
        KIND_SHORT  = 4'd6,
        KIND_BOOL   = 4'd7,
        KIND_INT    = 4'd8,
        KIND_REF    = 4'd9
    } t_kind;

    typedef struct packed {
        t_status                 status;
        logic [CountWidth-1:0]   slot_count;
        t_kind                   return_kind;
    } t_result;

    function automatic t_kind kind_of(input logic [CharWidth-1:0] c);
        t_kind k;
        unique case (c)
            ChVoid:          k = KIND_VOID;
            ChLong:          k = KIND_LONG;
            ChFloat:         k = KIND_FLOAT;
            ChDbl:           k = KIND_DOUBLE;
            ChByte:          k = KIND_BYTE;
            ChChar:          k = KIND_CHAR;
            ChShort:         k = KIND_SHORT;
            ChBool:          k = KIND_BOOL;
            ChRef, ChArray:  k = KIND_REF;
            default:         k = KIND_INT;
        endcase
        return k;
    endfunction

    function automatic logic [CountWidth-1:0] sat_add(
        input logic [CountWidth-1:0] a,
        input logic [1:0]            k
    );
        logic [CountWidth:0] s;
        s = {1'b0, a} + {{(CountWidth-1){1'b0}}, k};
        return s[CountWidth] ? {CountWidth{1'b1}} : s[CountWidth-1:0];
    endfunction

endpackage

### rtl/mdsc_parser.sv
module mdsc_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [mdsc_pkg::CharWidth-1:0]      i_ch,
    output mdsc_pkg::t_result                   o_result
);

    mdsc_pkg::t_mode                      r_mode;
    mdsc_pkg::t_mode                      n_mode;
    logic [mdsc_pkg::CountWidth-1:0]      r_slots;
    logic [mdsc_pkg::CountWidth-1:0]      n_slots;
    logic [mdsc_pkg::CountWidth-1:0]      s_slots;
    mdsc_pkg::t_mode                      s_mode;
    mdsc_pkg::t_status                    s_status;
    mdsc_pkg::t_kind                      s_kind;
    logic                                 s_fail;
    logic                                 s_restart;
    logic                                 s_term;

    assign s_term = (i_ch == mdsc_pkg::ChTerm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mdsc_pkg::MODE_OPEN;
            r_slots <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_slots <= n_slots;
        end
    end

    always_comb begin
        s_mode    = r_mode;
        s_slots   = r_slots;
        s_status  = mdsc_pkg::ST_PENDING;
        s_kind    = mdsc_pkg::KIND_VOID;
        s_fail    = 1'b0;
        s_restart = 1'b0;
        unique case (r_mode)
            mdsc_pkg::MODE_OPEN: begin
                if (i_ch == mdsc_pkg::ChOpen) begin
                    s_mode = mdsc_pkg::MODE_ARGS;
                end else begin
                    s_fail = 1'b1;
                end
            end
            mdsc_pkg::MODE_ARGS: begin
                priority if (s_term) begin
                    s_fail = 1'b1;
                end else if (i_ch == mdsc_pkg::ChClose) begin
                    s_mode = mdsc_pkg::MODE_RET;
                end else if (i_ch == mdsc_pkg::ChLong || i_ch == mdsc_pkg::ChDbl) begin
                    s_slots = mdsc_pkg::sat_add(r_slots, 2'd2);
                end else if (i_ch == mdsc_pkg::ChRef) begin
                    s_slots = mdsc_pkg::sat_add(r_slots, 2'd1);
                    s_mode  = mdsc_pkg::MODE_CLASS;
                end else if (i_ch == mdsc_pkg::ChArray) begin
                    s_mode = mdsc_pkg::MODE_ARRAY;
                end else begin
                    s_slots = mdsc_pkg::sat_add(r_slots, 2'd1);
                end
            end
            mdsc_pkg::MODE_CLASS: begin
                priority if (s_term) begin
                    s_fail = 1'b1;
                end else if (i_ch == mdsc_pkg::ChSemi) begin
                    s_mode = mdsc_pkg::MODE_ARGS;
                end
            end
            mdsc_pkg::MODE_ARRAY: begin
                priority if (s_term) begin
                    s_fail = 1'b1;
                end else if (i_ch == mdsc_pkg::ChRef) begin
                    s_slots = mdsc_pkg::sat_add(r_slots, 2'd1);
                    s_mode  = mdsc_pkg::MODE_CLASS;
                end else if (i_ch != mdsc_pkg::ChArray) begin
                    s_slots = mdsc_pkg::sat_add(r_slots, 2'd1);
                    s_mode  = mdsc_pkg::MODE_ARGS;
                end
            end
            mdsc_pkg::MODE_RET: begin
                s_status = mdsc_pkg::ST_COMPLETE;
                s_kind   = mdsc_pkg::kind_of(i_ch);
                if (s_term) begin
                    s_restart = 1'b1;
                end else begin
                    s_mode = mdsc_pkg::MODE_DRAIN;
                end
            end
            default: begin
                s_status = mdsc_pkg::ST_IGNORED;
                if (s_term) begin
                    s_restart = 1'b1;
                end
            end
        endcase

        if (s_fail) begin
            s_status = mdsc_pkg::ST_BAD;
            if (s_term) begin
                s_restart = 1'b1;
            end else begin
                s_mode = mdsc_pkg::MODE_DRAIN;
            end
        end

        n_mode  = s_restart ? mdsc_pkg::MODE_OPEN : s_mode;
        n_slots = s_restart ? '0 : s_slots;

        o_result.status      = s_status;
        o_result.slot_count  = s_slots;
        o_result.return_kind = s_kind;
    end

endmodule

### rtl/method_descriptor_slot_counter_core.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------
// input    | i_valid / o_ready  | i_ch
// output   | o_valid / i_ready  | o_status, o_slot_count, o_return_kind
//
// Each character is captured in an input register and then parsed into a result
// register, and one transaction is taken every cycle while the output flows.
// A stalled output holds the result register and then the input register, and
// o_ready drops only when both are full.
// Reset clears both valid flags and returns the parser to expect '('.
module method_descriptor_slot_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mdsc_pkg::CharWidth-1:0]      i_ch,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [mdsc_pkg::CountWidth-1:0]     o_slot_count,
    output logic [mdsc_pkg::KindWidth-1:0]      o_return_kind
);

    logic                                 r_in_valid;
    logic [mdsc_pkg::CharWidth-1:0]       r_ch;
    logic                                 r_out_valid;
    mdsc_pkg::t_result                    r_result;
    mdsc_pkg::t_result                    s_result;
    logic                                 s_step;

    assign s_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s_step;

    mdsc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_step),
        .i_ch     (r_ch),
        .o_result (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_result <= s_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_result.status;
    assign o_slot_count  = r_result.slot_count;
    assign o_return_kind = r_result.return_kind;

endmodule

### rtl/mdsc_checker.sv
module mdsc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic [mdsc_pkg::CharWidth-1:0]      i_ch,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [1:0]                          o_status,
    input  logic [mdsc_pkg::CountWidth-1:0]     o_slot_count,
    input  logic [mdsc_pkg::KindWidth-1:0]      o_return_kind
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_slot_count) && $stable(o_return_kind))
        else $error("output payload changed while stalled");

    // A waiting input transaction keeps its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_ch))
        else $error("input payload changed while waiting");

    a_kind_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != mdsc_pkg::ST_COMPLETE) |-> o_return_kind == '0)
        else $error("return kind set without a complete status");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_return_kind <= mdsc_pkg::KIND_REF)
        else $error("return kind out of range");

    // The input stalls only while a result waits on a stalled output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while the output was free");

endmodule

bind method_descriptor_slot_counter_core mdsc_checker u_mdsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_ch          (i_ch),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_slot_count  (o_slot_count),
    .o_return_kind (o_return_kind)
);
